// ===== hw/rtl/circular_deque_buffer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the circular deque buffer.
// Each macro checks a property on the rising clock edge with reset masking.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_BUFFER_ASSERT_SVH
`define CIRCULAR_DEQUE_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular deque buffer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular deque buffer: next-cycle check failed");

`endif

// ===== hw/rtl/cdb_pkg.sv =====
// ---------------------------------------------------------------------------
// Circular deque buffer package
// Shared sizes, codes, payload layouts and helper functions.
// ---------------------------------------------------------------------------
package cdb_pkg;

   // Store geometry.
   localparam int DEPTH   = 128;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FIELD_W = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [DATA_W-1:0] word_type;

   // Operation codes carried in the request.
   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_HEAD   = 2'd2,
      ACT_NOP        = 2'd3
   } action_type;

   // Status codes returned in the response.
   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   // Control sequencer states.
   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   // Request layout, lowest bits last in the list.
   typedef struct packed {
      logic [5:0]         pad;
      logic [FIELD_W-1:0] value;
      logic [1:0]         action;
   } req_type;

   // Response layout, lowest bits last in the list.
   typedef struct packed {
      logic [3:0]         pad;
      logic               is_full;
      logic               is_empty;
      logic [FIELD_W-1:0] rear_value;
      logic [FIELD_W-1:0] front_value;
      logic [1:0]         status;
   } rsp_type;

   // Advance an index with wrap-around.
   function automatic idx_type idx_next(idx_type i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   // Step an index back with wrap-around.
   function automatic idx_type idx_prev(idx_type i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : idx_type'(i - 1'b1);
   endfunction

   // Sign-extend or trim an input field to the stored word width.
   function automatic word_type to_word(logic [FIELD_W-1:0] v);
      return DATA_W'($signed(v));
   endfunction

   // Sign-extend or trim a stored word to the output field width.
   function automatic logic [FIELD_W-1:0] to_field(word_type w);
      return FIELD_W'($signed(w));
   endfunction

endpackage

// ===== hw/rtl/cdb_ram.sv =====
// ---------------------------------------------------------------------------
// Circular deque buffer slot RAM
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module cdb_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cdb_rsp_buf.sv =====
// ---------------------------------------------------------------------------
// Circular deque buffer response stage
// Output register plus a skid entry, so a new request can be taken while
// a finished response is still waiting at the port.
// ---------------------------------------------------------------------------
module cdb_rsp_buf (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cdb_pkg::rsp_type push_data,
   output logic            room,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output cdb_pkg::rsp_type rsp_tdata
);

   logic             main_valid_ff, main_valid_in;
   logic             hold_valid_ff, hold_valid_in;
   cdb_pkg::rsp_type main_data_ff, main_data_in;
   cdb_pkg::rsp_type hold_data_ff, hold_data_in;
   logic             drain;

   assign drain = main_valid_ff && rsp_tready;

   // Refill the output register from the skid entry or the new response.
   always_comb begin
      main_valid_in = main_valid_ff;
      hold_valid_in = hold_valid_ff;
      main_data_in  = main_data_ff;
      hold_data_in  = hold_data_ff;
      if (!main_valid_ff || drain) begin
         if (hold_valid_ff) begin
            main_data_in  = hold_data_ff;
            main_valid_in = 1'b1;
            hold_valid_in = push;
            hold_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         hold_valid_in = 1'b1;
         hold_data_in  = push_data;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign room       = !hold_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

endmodule

// ===== hw/rtl/circular_deque_buffer.sv =====
// ---------------------------------------------------------------------------
// Circular deque buffer
// Double-ended queue in a circular slot RAM: push front, push back and
// pop front, one response per request.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   req_*    in         tdata: action[1:0], value[33:2], zero pad to 40 bits
//   rsp_*    out        tdata: status, front_value, rear_value, is_empty,
//                              is_full, zero pad to 72 bits
//
// A push, a rejected request or a pop of the last word is answered from the
// idle state. A pop that leaves words behind passes through the read state: the
// new front word is read from the slot RAM, whose read port is registered.
// After reset the deque is empty; the RAM needs no clearing.
// A stalled response port holds up new requests only once the skid entry
// behind the output register is also occupied.
//
module circular_deque_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action[1:0], value[33:2], pad[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status[1:0], front[33:2], rear[65:34],
                                    // is_empty[66], is_full[67], pad[71:68]
);

`include "circular_deque_buffer_assert.svh"

   cdb_pkg::state_type state_ff, state_in;
   cdb_pkg::idx_type   head_ff, head_in;
   cdb_pkg::idx_type   tail_ff, tail_in;
   logic               empty_ff, empty_in;
   cdb_pkg::word_type  front_ff, front_in;
   cdb_pkg::word_type  rear_ff, rear_in;

   cdb_pkg::req_type   req;
   cdb_pkg::rsp_type   rsp_push_data;
   cdb_pkg::rsp_type   rsp_out;
   cdb_pkg::word_type  in_word;
   logic               accept;
   logic               full_now;
   logic               pop_wait;
   logic               rsp_push;
   logic               room;
   logic               mem_we;
   cdb_pkg::idx_type   mem_waddr;
   logic               mem_re;
   cdb_pkg::word_type  mem_rdata;
   logic               in_read;

   assign req     = cdb_pkg::req_type'(req_tdata);
   assign in_word = cdb_pkg::to_word(req.value);
   assign accept  = req_tvalid && req_tready;
   assign full_now = !empty_ff && (cdb_pkg::idx_next(tail_ff) == head_ff);
   assign in_read = (state_ff == cdb_pkg::S_READ);

   // A pop that leaves words behind must fetch the new front word.
   assign pop_wait = accept && (cdb_pkg::action_type'(req.action) == cdb_pkg::ACT_POP_HEAD)
                     && !empty_ff && (head_ff != tail_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdb_pkg::S_IDLE: begin
            if (pop_wait) begin
               state_in = cdb_pkg::S_READ;
            end
         end
         cdb_pkg::S_READ: begin
            state_in = cdb_pkg::S_IDLE;
         end
         default: begin
            state_in = cdb_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs and datapath: pointer updates, RAM access and the response.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_re        = 1'b0;
      rsp_push      = 1'b0;
      rsp_push_data = '0;
      case (state_ff)
         cdb_pkg::S_IDLE: begin
            req_tready = room;
            if (accept) begin
               rsp_push_data.status = cdb_pkg::STS_DONE;
               case (cdb_pkg::action_type'(req.action))
                  cdb_pkg::ACT_PUSH_FRONT, cdb_pkg::ACT_PUSH_REAR: begin
                     if (full_now) begin
                        rsp_push_data.status = cdb_pkg::STS_FULL;
                     end else if (empty_ff) begin
                        head_in   = '0;
                        tail_in   = '0;
                        empty_in  = 1'b0;
                        front_in  = in_word;
                        rear_in   = in_word;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                     end else if (cdb_pkg::action_type'(req.action) ==
                                  cdb_pkg::ACT_PUSH_FRONT) begin
                        head_in   = cdb_pkg::idx_prev(head_ff);
                        front_in  = in_word;
                        mem_we    = 1'b1;
                        mem_waddr = head_in;
                     end else begin
                        tail_in   = cdb_pkg::idx_next(tail_ff);
                        rear_in   = in_word;
                        mem_we    = 1'b1;
                        mem_waddr = tail_in;
                     end
                  end
                  cdb_pkg::ACT_POP_HEAD: begin
                     if (empty_ff) begin
                        rsp_push_data.status = cdb_pkg::STS_EMPTY;
                     end else if (head_ff == tail_ff) begin
                        empty_in = 1'b1;
                        head_in  = '0;
                        tail_in  = '0;
                     end else begin
                        head_in = cdb_pkg::idx_next(head_ff);
                        mem_re  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               // Response from the state after the operation.
               rsp_push = !pop_wait;
               rsp_push_data.is_empty    = empty_in;
               rsp_push_data.is_full     = !empty_in &&
                                           (cdb_pkg::idx_next(tail_in) == head_in);
               rsp_push_data.front_value = empty_in ? '1 : cdb_pkg::to_field(front_in);
               rsp_push_data.rear_value  = empty_in ? '1 : cdb_pkg::to_field(rear_in);
            end
         end
         cdb_pkg::S_READ: begin
            // The fetched word becomes the cached front; the deque is neither
            // empty nor full after such a pop.
            req_tready = 1'b0;
            front_in   = mem_rdata;
            rsp_push   = 1'b1;
            rsp_push_data.status      = cdb_pkg::STS_DONE;
            rsp_push_data.is_empty    = 1'b0;
            rsp_push_data.is_full     = 1'b0;
            rsp_push_data.front_value = cdb_pkg::to_field(mem_rdata);
            rsp_push_data.rear_value  = cdb_pkg::to_field(rear_ff);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdb_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // Cached end words.
   always_ff @(posedge clock) begin
      front_ff <= front_in;
      rear_ff  <= rear_in;
   end

   // Slot store.
   cdb_ram #(
      .DEPTH (cdb_pkg::DEPTH),
      .WIDTH (cdb_pkg::DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (in_word),
      .rd_en   (mem_re),
      .rd_addr (head_in),
      .rd_data (mem_rdata)
   );

   // Response stage.
   cdb_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_data  (rsp_push_data),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_out)
   );

   assign rsp_tdata = rsp_out;

   // Checks on the sequencer and pointers.
   `CDB_ASSERT_SAME(a_empty_ptrs, clock, reset, empty_ff, (head_ff == '0) && (tail_ff == '0))
   `CDB_ASSERT_NEXT(a_read_one_cycle, clock, reset, in_read, !in_read)
   `CDB_ASSERT_NEXT(a_pop_fetch, clock, reset, pop_wait, in_read && !empty_ff)

endmodule
